### hw/rtl/dnda_pkg.sv
// Shared types, constants and activation tables for the dense neuron engine.
`default_nettype none

package dnda_pkg;

  localparam int MAX_NEURONS       = 256;
  localparam int ACT_TABLE_ENTRIES = 256;
  localparam int ACT_IDX_W         = $clog2(ACT_TABLE_ENTRIES);

  localparam int VAL_W     = 16;
  localparam int PROD_W    = 32;
  localparam int ACC_W     = 40;
  localparam int CNT_W     = 8;
  localparam int NEURONS_W = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;

  localparam int LEN_CAP = (MAX_NEURONS < 256) ? MAX_NEURONS : 256;

  localparam logic [63:0] Q31_ONE = 64'd1 << 31;

  typedef enum logic [1:0] {
    ACT_SIGMOID  = 2'd0,
    ACT_TANH     = 2'd1,
    ACT_RELU     = 2'd2,
    ACT_IDENTITY = 2'd3
  } act_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACT_MODE    = 2'd0,
    CFG_IGNORE_MASK = 2'd1,
    CFG_NEURONS     = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    act_mode_e              act_mode;
    logic                   ignore_mask;
    logic [NEURONS_W-1:0]   neurons;
  } dnda_cfg_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] total;
    logic [CNT_W-1:0]        index;
    logic                    last_neuron;
  } dnda_sum_t;

  typedef logic [ACT_TABLE_ENTRIES-1:0][VAL_W-1:0] act_lut_t;

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] exp_neg(input logic [31:0] u);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] acc;
    y    = 64'(u) << 13;
    term = Q31_ONE;
    acc  = Q31_ONE;
    for (int k = 1; k <= 7; k++) begin
      term = udiv64((term * y) >> 31, 64'(k));
      if ((k % 2) == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    for (int k = 0; k < 6; k++) begin
      acc = (acc * acc) >> 31;
    end
    return acc;
  endfunction

  function automatic act_lut_t build_lut(input logic is_tanh);
    act_lut_t    lut;
    logic [31:0] num;
    int          x;
    logic [31:0] ax;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] t;
    lut = '0;
    for (int i = 0; i < ACT_TABLE_ENTRIES; i++) begin
      num = 32'(2 * i + 1) * 32'd32768;
      x   = -32768 + int'(num / ACT_TABLE_ENTRIES);
      ax  = (x < 0) ? 32'(-x) : 32'(x);
      if (!is_tanh) begin
        e = exp_neg(ax);
        d = Q31_ONE + e;
        if (x >= 0) begin
          s = udiv64((Q31_ONE << 12) + (d >> 1), d);
        end else begin
          s = udiv64((e << 12) + (d >> 1), d);
        end
        lut[i] = s[VAL_W-1:0];
      end else begin
        e = exp_neg(ax << 1);
        d = Q31_ONE + e;
        t = udiv64(((Q31_ONE - e) << 12) + (d >> 1), d);
        if (x < 0) begin
          t = 64'd0 - t;
        end
        lut[i] = t[VAL_W-1:0];
      end
    end
    return lut;
  endfunction

  localparam act_lut_t SIG_LUT  = build_lut(1'b0);
  localparam act_lut_t TANH_LUT = build_lut(1'b1);

endpackage

`default_nettype wire

### hw/rtl/dense_neuron_dropout_activation.sv
// Top level of the dense neuron engine: configuration registers and datapath.
`default_nettype none

// Computes one dense-layer neuron at a time from a stream of weight/activation
// pairs in signed Q4.12. Every pair is a transaction and one is taken per clock
// cycle while in_stall_o is low; the pace is set by the 40-bit saturating
// accumulator. A pair marked last_term yields one result on the outputs once it
// has passed the product register, the sum register and the output register;
// other pairs yield none. The bias is added and the dropout keep bit applied on
// the last term, the sum is rounded half up to Q4.12 with saturation, and
// sigmoid, tanh, ReLU or identity is applied; sigmoid and tanh come from
// 256-entry constant tables over [-8,8) that clamp at the ends. The
// configuration port is always ready; write it only while no transaction is
// in flight.
module dense_neuron_dropout_activation import dnda_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [VAL_W-1:0]   weight_i,
  input  logic signed [VAL_W-1:0]   activation_in_i,
  input  logic signed [VAL_W-1:0]   bias_i,
  input  logic                      keep_i,
  input  logic                      last_term_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [VAL_W-1:0]   neuron_value_o,
  output logic [CNT_W-1:0]          neuron_index_o,
  output logic                      last_neuron_o
);

  act_mode_e             act_mode_q;
  logic                  ignore_mask_q;
  logic [NEURONS_W-1:0]  neurons_q;
  dnda_cfg_t             cfg;

  logic                  sum_valid;
  logic                  sum_ready;
  dnda_sum_t             sum;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_mode_q    <= ACT_SIGMOID;
      ignore_mask_q <= 1'b0;
      neurons_q     <= NEURONS_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ACT_MODE:    act_mode_q    <= act_mode_e'(cfg_data_i[1:0]);
        CFG_IGNORE_MASK: ignore_mask_q <= cfg_data_i[0];
        CFG_NEURONS:     neurons_q     <= cfg_data_i[NEURONS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.act_mode    = act_mode_q;
  assign cfg.ignore_mask = ignore_mask_q;
  assign cfg.neurons     = neurons_q;

  dnda_mac u_mac (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .weight_i        (weight_i),
    .activation_in_i (activation_in_i),
    .bias_i          (bias_i),
    .keep_i          (keep_i),
    .last_term_i     (last_term_i),
    .sum_valid_o     (sum_valid),
    .sum_ready_i     (sum_ready),
    .sum_o           (sum)
  );

  dnda_act u_act (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .act_mode_i     (cfg.act_mode),
    .sum_valid_i    (sum_valid),
    .sum_ready_o    (sum_ready),
    .sum_i          (sum),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .neuron_value_o (neuron_value_o),
    .neuron_index_o (neuron_index_o),
    .last_neuron_o  (last_neuron_o)
  );

endmodule

`default_nettype wire

### hw/rtl/dnda_mac.sv
// Product register, saturating accumulator, bias and dropout stage, neuron counter.
`default_nettype none

module dnda_mac import dnda_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dnda_cfg_t               cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [VAL_W-1:0] weight_i,
  input  logic signed [VAL_W-1:0] activation_in_i,
  input  logic signed [VAL_W-1:0] bias_i,
  input  logic                    keep_i,
  input  logic                    last_term_i,
  output logic                    sum_valid_o,
  input  logic                    sum_ready_i,
  output dnda_sum_t               sum_o
);

  function automatic logic signed [ACC_W-1:0] sat40(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  logic                     s1_valid_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [VAL_W-1:0]  bias_q;
  logic                     keep_q;
  logic                     last_q;

  logic                     s2_valid_q;
  dnda_sum_t                sum_q;

  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;

  logic                     s1_ld, s2_ld, s1_adv;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [VAL_W+11:0] bias_sh;
  logic signed [ACC_W-1:0]  total_raw;
  logic signed [ACC_W-1:0]  total;
  logic                     drop;
  logic [NEURONS_W-1:0]     eff_len;
  logic [NEURONS_W-1:0]     cnt_inc;
  logic                     is_last;

  assign s2_ld      = !s2_valid_q || sum_ready_i;
  assign s1_ld      = !s1_valid_q || s2_ld;
  assign s1_adv     = s1_valid_q && s2_ld;
  assign in_stall_o = !s1_ld;

  assign acc_sum   = sat40((ACC_W+1)'(acc_q) + (ACC_W+1)'(prod_q));
  assign bias_sh   = {bias_q, 12'd0};
  assign total_raw = sat40((ACC_W+1)'(acc_sum) + (ACC_W+1)'(bias_sh));
  assign drop      = !cfg_i.ignore_mask && !keep_q;
  assign total     = drop ? '0 : total_raw;

  assign eff_len = (cfg_i.neurons == '0 || cfg_i.neurons > NEURONS_W'(LEN_CAP))
                   ? NEURONS_W'(LEN_CAP) : cfg_i.neurons;
  assign cnt_inc = {1'b0, cnt_q} + NEURONS_W'(1);
  assign is_last = cnt_inc >= eff_len;

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (s1_adv) begin
      acc_d = last_q ? '0 : acc_sum;
      if (last_q) begin
        cnt_d = is_last ? '0 : cnt_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      acc_q      <= '0;
      cnt_q      <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      if (s1_ld) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ld) begin
        s2_valid_q <= s1_valid_q && last_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ld) begin
      prod_q <= weight_i * activation_in_i;
      bias_q <= bias_i;
      keep_q <= keep_i;
      last_q <= last_term_i;
    end
    if (s1_adv && last_q) begin
      sum_q.total       <= total;
      sum_q.index       <= cnt_q;
      sum_q.last_neuron <= is_last;
    end
  end

  assign sum_valid_o = s2_valid_q;
  assign sum_o       = sum_q;

`ifndef ASSERT_OFF
  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && last_q && s2_ld) |=> (acc_q == '0))
    else $error("accumulator not cleared after last term");

  a_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !sum_ready_i) |=> (s2_valid_q && $stable(sum_q)))
    else $error("pending sum lost or changed");

  a_sum_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s2_valid_q) |-> $past(s1_valid_q && last_q))
    else $error("sum without a last term");
`endif

endmodule

`default_nettype wire

### hw/rtl/dnda_act.sv
// Rounding to Q4.12, activation function and output register.
`default_nettype none

module dnda_act import dnda_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  act_mode_e               act_mode_i,
  input  logic                    sum_valid_i,
  output logic                    sum_ready_o,
  input  dnda_sum_t               sum_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [VAL_W-1:0] neuron_value_o,
  output logic [CNT_W-1:0]        neuron_index_o,
  output logic                    last_neuron_o
);

  localparam int SHF_W  = ACC_W + 1 - 12;
  localparam int IPROD_W = VAL_W + ACT_IDX_W;

  logic                     out_valid_q;
  logic signed [VAL_W-1:0]  value_q;
  logic [CNT_W-1:0]         index_q;
  logic                     last_q;

  logic                     en;
  logic signed [ACC_W:0]    rnd;
  logic signed [SHF_W-1:0]  shf;
  logic                     ovf;
  logic signed [VAL_W-1:0]  pre;
  logic [VAL_W-1:0]         upre;
  logic [IPROD_W-1:0]       iprod;
  logic [ACT_IDX_W-1:0]     idx;
  logic signed [VAL_W-1:0]  value;

  assign en          = !out_valid_q || !out_stall_i;
  assign sum_ready_o = en;

  assign rnd = (ACC_W+1)'(sum_i.total) + (ACC_W+1)'(2048);
  assign shf = rnd[ACC_W:12];
  assign ovf = !((&shf[SHF_W-1:VAL_W-1]) || !(|shf[SHF_W-1:VAL_W-1]));
  assign pre = ovf ? (shf[SHF_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}})
                   : shf[VAL_W-1:0];

  assign upre  = pre ^ {1'b1, {(VAL_W-1){1'b0}}};
  assign iprod = IPROD_W'(upre) * IPROD_W'(ACT_TABLE_ENTRIES);
  assign idx   = iprod[IPROD_W-1:VAL_W];

  always_comb begin
    unique case (act_mode_i)
      ACT_SIGMOID:  value = SIG_LUT[idx];
      ACT_TANH:     value = TANH_LUT[idx];
      ACT_RELU:     value = pre[VAL_W-1] ? '0 : pre;
      ACT_IDENTITY: value = pre;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sum_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && sum_valid_i) begin
      value_q <= value;
      index_q <= sum_i.index;
      last_q  <= sum_i.last_neuron;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign neuron_value_o = value_q;
  assign neuron_index_o = index_q;
  assign last_neuron_o  = last_q;

`ifndef ASSERT_OFF
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(sum_valid_i))
    else $error("result without a pending sum");
`endif

endmodule

`default_nettype wire

### dv/dense_neuron_dropout_activation_tb.sv
// Self-checking testbench for the dense neuron engine with dropout and activation.
`timescale 1ns / 1ps

module dense_neuron_dropout_activation_tb import dnda_pkg::*; ();

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int LONG_TERMS      = 520;
  localparam int HOLD_CYCLES     = 80;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        index;
    logic                    last;
  } neuron_result_t;

  class neuron_predictor;
    localparam longint ACC_HI = (longint'(1) << (ACC_W - 1)) - 1;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint unsigned ONE31 = 64'd1 << 31;

    act_mode_e               mode;
    logic                    ignore_mask;
    logic [NEURONS_W-1:0]    layer_len;
    longint                  acc;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] sig_tab [ACT_TABLE_ENTRIES];
    logic signed [VAL_W-1:0] tanh_tab [ACT_TABLE_ENTRIES];
    neuron_result_t          pending_neurons [$];
    int                      mismatches;

    function new();
      mode        = ACT_SIGMOID;
      ignore_mask = 1'b0;
      layer_len   = 1;
      acc         = 0;
      count       = '0;
      mismatches  = 0;
      build_tables();
    endfunction

    function longint unsigned exp_decay(int unsigned u);
      longint unsigned y;
      longint unsigned term;
      longint unsigned sum;
      y    = longint'(u) << 13;
      term = ONE31;
      sum  = ONE31;
      for (int k = 1; k <= 7; k++) begin
        term = ((term * y) >> 31) / longint'(k);
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      for (int k = 0; k < 6; k++) begin
        sum = (sum * sum) >> 31;
      end
      return sum;
    endfunction

    function void build_tables();
      int              x;
      int unsigned     ax;
      longint unsigned e;
      longint unsigned d;
      longint unsigned s;
      longint unsigned t;
      for (int i = 0; i < ACT_TABLE_ENTRIES; i++) begin
        x  = -32768 + ((2 * i + 1) * 32768) / ACT_TABLE_ENTRIES;
        ax = (x < 0) ? -x : x;
        e  = exp_decay(ax);
        d  = ONE31 + e;
        if (x >= 0) begin
          s = ((ONE31 << 12) + d / 2) / d;
        end else begin
          s = ((e << 12) + d / 2) / d;
        end
        sig_tab[i] = s[VAL_W-1:0];
        e = exp_decay(2 * ax);
        d = ONE31 + e;
        t = (((ONE31 - e) << 12) + d / 2) / d;
        tanh_tab[i] = (x < 0) ? -t[VAL_W-1:0] : t[VAL_W-1:0];
      end
    endfunction

    function longint sat40(longint v);
      if (v > ACC_HI) return ACC_HI;
      if (v < ACC_LO) return ACC_LO;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ACT_MODE:    mode = act_mode_e'(data[1:0]);
        CFG_IGNORE_MASK: ignore_mask = data[0];
        CFG_NEURONS:     layer_len = data[NEURONS_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_pair(logic signed [VAL_W-1:0] w, logic signed [VAL_W-1:0] a,
                            logic signed [VAL_W-1:0] b, logic keep, logic last);
      longint                  total;
      longint                  rounded;
      logic signed [VAL_W-1:0] pre;
      int                      idx;
      int                      len;
      neuron_result_t          r;
      acc = sat40(acc + longint'(w) * longint'(a));
      if (!last) return;
      total = sat40(acc + longint'(b) * 4096);
      if (!ignore_mask && !keep) total = 0;
      acc = 0;
      rounded = (total + 2048) >>> 12;
      if (rounded > 32767) rounded = 32767;
      if (rounded < -32768) rounded = -32768;
      pre = rounded[VAL_W-1:0];
      idx = ((int'(pre) + 32768) * ACT_TABLE_ENTRIES) >> 16;
      if (idx >= ACT_TABLE_ENTRIES) idx = ACT_TABLE_ENTRIES - 1;
      case (mode)
        ACT_SIGMOID: r.value = sig_tab[idx];
        ACT_TANH:    r.value = tanh_tab[idx];
        ACT_RELU:    r.value = (pre < 0) ? '0 : pre;
        default:     r.value = pre;
      endcase
      len = int'(layer_len);
      if (len == 0 || len > MAX_NEURONS) len = MAX_NEURONS;
      if (len > 256) len = 256;
      r.index = count;
      r.last  = (int'(count) + 1 >= len);
      pending_neurons.push_back(r);
      count = r.last ? '0 : count + 1'b1;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_neuron(logic signed [VAL_W-1:0] value, logic [CNT_W-1:0] index,
                               logic last);
      neuron_result_t want;
      if (pending_neurons.size() == 0) begin
        flag($sformatf("unexpected transaction: value %0d index %0d last %0b",
                       value, index, last));
        return;
      end
      want = pending_neurons.pop_front();
      if (value !== want.value)
        flag($sformatf("neuron_value: expected %0d, got %0d (index %0d)",
                       want.value, value, want.index));
      if (index !== want.index)
        flag($sformatf("neuron_index: expected %0d, got %0d", want.index, index));
      if (last !== want.last)
        flag($sformatf("last_neuron: expected %0b, got %0b (index %0d)",
                       want.last, last, want.index));
    endfunction

    function int pending();
      return pending_neurons.size();
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic signed [VAL_W-1:0] weight_i;
  logic signed [VAL_W-1:0] activation_in_i;
  logic signed [VAL_W-1:0] bias_i;
  logic                    keep_i;
  logic                    last_term_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [VAL_W-1:0] neuron_value_o;
  logic [CNT_W-1:0]        neuron_index_o;
  logic                    last_neuron_o;

  neuron_predictor predictor = new();
  bit quiet;
  int results_seen;
  int terms_left;
  bit want_long;
  bit in_long;
  bit long_negative;

  dense_neuron_dropout_activation dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      predictor.check_neuron(neuron_value_o, neuron_index_o, last_neuron_o);
      results_seen++;
    end
  end

  initial begin : sink
    int burst;
    bit held;
    burst = 0;
    held  = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= 40) begin
        out_stall_i = 1'b1;
        held = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i = 1'b0;
      end else if (burst > 0) begin
        out_stall_i = 1'b1;
        burst--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i = 1'b1;
        burst = $urandom_range(1, 7) - 1;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return VAL_W'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return VAL_W'($urandom_range(0, 8192)) - 16'sd4096;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    predictor.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_item(input logic signed [VAL_W-1:0] w, input logic signed [VAL_W-1:0] a,
                           input logic signed [VAL_W-1:0] b, input logic keep,
                           input logic last);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    weight_i        = w;
    activation_in_i = a;
    bias_i          = b;
    keep_i          = keep;
    last_term_i     = last;
    do @(posedge clk_i); while (in_stall_o);
    predictor.take_pair(w, a, b, keep, last);
    @(negedge clk_i);
  endtask

  task automatic send_random_item();
    logic signed [VAL_W-1:0] w;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic                    keep;
    logic                    last;
    if (terms_left == 0) begin
      if (want_long) begin
        terms_left = LONG_TERMS;
        in_long    = 1'b1;
        want_long  = 1'b0;
      end else if ($urandom_range(0, 19) == 0) begin
        terms_left = $urandom_range(9, 40);
      end else begin
        terms_left = $urandom_range(1, 8);
      end
    end
    last = (terms_left == 1);
    if (in_long && !last) begin
      w = 16'sh8000;
      a = long_negative ? 16'sh7FFF : 16'sh8000;
    end else begin
      w = pick_value();
      a = pick_value();
    end
    b    = pick_value();
    keep = ($urandom_range(0, 3) != 0);
    terms_left--;
    if (last) in_long = 1'b0;
    send_item(w, a, b, keep, last);
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (predictor.pending() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  initial begin : stimulus
    act_mode_e            modes [6]   = '{ACT_SIGMOID, ACT_TANH, ACT_RELU, ACT_IDENTITY,
                                          ACT_SIGMOID, ACT_TANH};
    bit                   ignores [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    int                   lens [6]    = '{1, 256, 3, 511, 300, 7};
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_ACT_MODE;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    weight_i        = '0;
    activation_in_i = '0;
    bias_i          = '0;
    keep_i          = 1'b0;
    last_term_i     = 1'b0;
    quiet           = 1'b0;
    results_seen    = 0;
    terms_left      = 0;
    want_long       = 1'b0;
    in_long         = 1'b0;
    long_negative   = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_reg(CFG_ACT_MODE, CFG_DATA_W'(ACT_IDENTITY));
    write_reg(CFG_NEURONS, 9'd4);
    send_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1);
    send_item(16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1'b1);
    send_item(16'sh8000, 16'sh7FFF, 16'sh0000, 1'b1, 1'b1);
    send_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b1);
    send_item(16'sd1, 16'sd2048, 16'sd0, 1'b1, 1'b1);
    send_item(-16'sd1, 16'sd2048, 16'sd0, 1'b1, 1'b1);
    send_item(16'sd4096, 16'sd4096, 16'sd0, 1'b1, 1'b0);
    send_item(16'sd4096, -16'sd8192, 16'sd0, 1'b0, 1'b0);
    send_item(16'sd0, 16'sd0, 16'sd4096, 1'b1, 1'b1);
    settle();

    write_reg(CFG_ACT_MODE, {7'h7F, ACT_RELU});
    write_reg(CFG_IGNORE_MASK, 9'h1FF);
    send_item(-16'sd4096, 16'sd4096, 16'sd0, 1'b0, 1'b1);
    send_item(16'sd4096, 16'sd4096, 16'sd0, 1'b0, 1'b1);
    settle();

    write_reg(CFG_ACT_MODE, {7'h55, ACT_SIGMOID});
    write_reg(CFG_IGNORE_MASK, 9'h1FE);
    write_reg(CFG_NEURONS, 9'd0);
    send_item(16'sh7FFF, 16'sh7FFF, 16'sd0, 1'b1, 1'b1);
    send_item(16'sh8000, 16'sh7FFF, 16'sd0, 1'b1, 1'b1);
    send_item(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1);
    send_item(16'sd0, 16'sd0, 16'sh8000, 1'b1, 1'b1);
    settle();

    write_reg(CFG_ACT_MODE, CFG_DATA_W'(ACT_TANH));
    write_reg(CFG_NEURONS, 9'd2);
    write_reg(CFG_UNMAPPED, 9'h1FF);
    send_item(16'sd8192, 16'sd4096, 16'sd0, 1'b1, 1'b1);
    send_item(-16'sd8192, 16'sd4096, 16'sd0, 1'b1, 1'b1);
    send_item(16'sd0, 16'sd0, 16'sh7FFF, 1'b1, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p < 6) begin
        write_reg(CFG_ACT_MODE, CFG_DATA_W'(modes[p]));
        write_reg(CFG_IGNORE_MASK, CFG_DATA_W'(ignores[p]));
        write_reg(CFG_NEURONS, CFG_DATA_W'(lens[p]));
      end else begin
        write_reg(CFG_ACT_MODE, CFG_DATA_W'($urandom));
        write_reg(CFG_IGNORE_MASK, CFG_DATA_W'($urandom));
        if ($urandom_range(0, 1) == 0) begin
          write_reg(CFG_NEURONS, CFG_DATA_W'($urandom_range(1, 12)));
        end else begin
          write_reg(CFG_NEURONS, CFG_DATA_W'($urandom));
        end
      end
      if (p == 2 || p == 5) begin
        want_long     = 1'b1;
        long_negative = (p == 5);
      end
      if (p == PHASES - 1) quiet = 1'b1;
      repeat (ITEMS_PER_PHASE) send_random_item();
    end

    settle();
    repeat (10) @(negedge clk_i);
    if (predictor.mismatches == 0 && predictor.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
